### src/sc3_pkg.sv
// Package for the 3x3 cross stencil: field widths, register indexes,
// the result type and the stencil arithmetic. Depends on nothing.
package sc3_pkg;

    localparam int PIXEL_W      = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd4096;

    localparam int MIN_SIZE    = 3;
    localparam int CENTER_GAIN = 5;

    // Result queue: three entries, so a full rate stream never stalls while
    // one result waits in the queue and another is on its way.
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 2;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t pixel;
        logic   last;
    } result_t;

    // up + down + left + right - 5 * centre, wrapped modulo 256.
    function automatic pixel_t cross_stencil(input pixel_t up, input pixel_t down,
                                             input pixel_t left, input pixel_t right,
                                             input pixel_t center);
        pixel_t gain;
        pixel_t weighted;
        gain     = PIXEL_W'(CENTER_GAIN);
        weighted = pixel_t'(gain * center);
        return pixel_t'(up + down + left + right - weighted);
    endfunction

endpackage

### src/sc3_pixel_cell.sv
// One window cell: a pixel register that takes its neighbour's pixel on
// every shift. Depends on sc3_pkg.
module sc3_pixel_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  sc3_pkg::pixel_t pixel_d,
    output sc3_pkg::pixel_t pixel_q
);

    sc3_pkg::pixel_t pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= '0;
        end
        else if (shift_en)
        begin
            pixel_reg <= pixel_d;
        end
    end

    assign pixel_q = pixel_reg;

endmodule

### src/sc3_line_buffer.sv
// The two line memories, one row apart, with registered read data.
// Depends on sc3_pkg.
module sc3_line_buffer
#(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  sc3_pkg::pixel_t newer_wr_data,
    input  logic            older_wr_en,
    input  logic [AW-1:0]   older_wr_addr,
    input  sc3_pkg::pixel_t older_wr_data,
    output sc3_pkg::pixel_t older_q,
    output sc3_pkg::pixel_t newer_q
);

    sc3_pkg::pixel_t older_mem [DEPTH];
    sc3_pkg::pixel_t newer_mem [DEPTH];
    sc3_pkg::pixel_t older_q_reg;
    sc3_pkg::pixel_t newer_q_reg;

    // The newer row is read and overwritten at the same column in the same cycle;
    // the read returns the pixel from the row above.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            newer_q_reg        <= newer_mem[rd_addr];
            newer_mem[rd_addr] <= newer_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            older_q_reg <= older_mem[rd_addr];
        end
        if (older_wr_en)
        begin
            older_mem[older_wr_addr] <= older_wr_data;
        end
    end

    assign older_q = older_q_reg;
    assign newer_q = newer_q_reg;

endmodule

### src/sc3_out_fifo.sv
// Small result queue that parts the stencil from the output stream.
// Depends on sc3_pkg.
module sc3_out_fifo
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  sc3_pkg::result_t                push_data,
    input  logic                            pop,
    output sc3_pkg::result_t                head,
    output logic                            not_empty,
    output logic [sc3_pkg::OUT_CNT_W-1:0]   count
);

    sc3_pkg::result_t                    store_reg [sc3_pkg::OUT_DEPTH];
    logic [sc3_pkg::OUT_PTR_W-1:0]       wr_ptr_reg;
    logic [sc3_pkg::OUT_PTR_W-1:0]       rd_ptr_reg;
    logic [sc3_pkg::OUT_CNT_W-1:0]       count_reg;
    logic [sc3_pkg::OUT_PTR_W-1:0]       wr_ptr_next;
    logic [sc3_pkg::OUT_PTR_W-1:0]       rd_ptr_next;
    logic [sc3_pkg::OUT_CNT_W-1:0]       count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sc3_pkg::OUT_PTR_W'(sc3_pkg::OUT_DEPTH - 1))
                        ? '0 : wr_ptr_reg + sc3_pkg::OUT_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sc3_pkg::OUT_PTR_W'(sc3_pkg::OUT_DEPTH - 1))
                        ? '0 : rd_ptr_reg + sc3_pkg::OUT_PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + sc3_pkg::OUT_CNT_W'(1);
            2'b01:   count_next = count_reg - sc3_pkg::OUT_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = store_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

### src/stencil_3x3_cross_convolution.sv
// Top level of the streaming 3x3 cross stencil for 8-bit grayscale images.
// Depends on sc3_pkg, sc3_pixel_cell, sc3_line_buffer and sc3_out_fifo.

// Pixels arrive in raster order on the slave stream, one request per pixel,
// and the block takes one pixel in every clock cycle for as long as the
// output stream keeps taking results. For every interior pixel (not in the
// first or last row or column) it sends up + down + left + right minus five
// times the centre, wrapped to 8 bits. The result belongs to the request that
// brings in the pixel below and to the right of the centre. With the request
// the pixel is registered in stage one while the line memories are read into
// their read data registers; the stencil is formed from that data and the
// window as it stands, and the result enters the output queue as the window
// moves on, and is offered on the result stream from the queue. A request
// is refused only while the three-entry output queue, counting a result
// still being formed, has no room; with the output stream always ready, one
// request is taken in every cycle. Border pixels give no result. tlast marks
// the final interior result of an image, after which the counters start a
// new image. Image width and height are written through the configuration
// port; the user is to write them only while the block is idle, which the
// block itself does not enforce. Sizes below three are used as three and
// sizes above MAX_WIDTH or MAX_HEIGHT are clamped. The line memories need no
// clearing pass: every entry is written one row before it is read.

module stencil_3x3_cross_convolution
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [sc3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sc3_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input pixel stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] pixel_in
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] pixel_out
    output logic                               m_tlast    // last_pixel
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Configuration registers keep the bits as written.
    logic [sc3_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [sc3_pkg::HEIGHT_REG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sc3_pkg::WIDTH_RESET;
            height_reg <= sc3_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sc3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[sc3_pkg::WIDTH_REG_W-1:0];
                sc3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Effective image size after clamping.
    logic [WW-1:0] w_lim;
    logic [WW-1:0] w_last;
    logic [HW-1:0] h_lim;
    logic [HW-1:0] h_last;

    always_comb
    begin
        if (32'(width_reg) < sc3_pkg::MIN_SIZE)
        begin
            w_lim = WW'(sc3_pkg::MIN_SIZE);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_lim = WW'(MAX_WIDTH);
        end
        else
        begin
            w_lim = WW'(width_reg);
        end

        if (32'(height_reg) < sc3_pkg::MIN_SIZE)
        begin
            h_lim = HW'(sc3_pkg::MIN_SIZE);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_lim = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_lim = HW'(height_reg);
        end

        w_last = w_lim - WW'(1);
        h_last = h_lim - HW'(1);
    end

    // Position of the next pixel in the image.
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic          accept;
    logic          emit;
    logic          is_last;

    assign accept = s_tvalid & s_tready;

    always_comb
    begin
        // A result is due once the window around the pixel above and to the
        // left is complete; positions beyond a reduced size give nothing.
        emit = (row_reg >= RW'(2)) && (col_reg >= CW'(2))
            && (WW'(col_reg) < w_lim) && (HW'(row_reg) < h_lim);
        is_last = (WW'(col_reg) == w_last) && (HW'(row_reg) == h_last);

        col_next = col_reg + CW'(1);
        row_next = row_reg;
        // Reaching or passing the row end closes the row, and likewise for
        // the image, so a size that shrank mid-image takes effect at once.
        if (WW'(col_reg) >= w_last)
        begin
            col_next = '0;
            if (HW'(row_reg) >= h_last)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage one: the pixel waits here while the line memories are read.
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_last_reg;
    sc3_pkg::pixel_t s1_pixel_reg;
    logic [CW-1:0]   s1_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= emit;
            s1_last_reg  <= is_last;
            s1_pixel_reg <= s_tdata;
            s1_col_reg   <= col_reg;
        end
    end

    // Line memories: the newer row is replaced by the incoming pixel at
    // once, and the older row takes the pixel read from the newer one in the
    // next cycle.
    sc3_pkg::pixel_t older_q;
    sc3_pkg::pixel_t newer_q;

    sc3_line_buffer
    #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    )
    u_line_buffer
    (
        .clk           (clk),
        .rd_en         (accept),
        .rd_addr       (col_reg),
        .newer_wr_data (s_tdata),
        .older_wr_en   (s1_valid_reg),
        .older_wr_addr (s1_col_reg),
        .older_wr_data (newer_q),
        .older_q       (older_q),
        .newer_q       (newer_q)
    );

    // Window: a chain of pixel cells per row. The top and bottom rows need
    // only the previous column; the middle row keeps the previous two.
    sc3_pkg::pixel_t up_q;
    sc3_pkg::pixel_t center_q;
    sc3_pkg::pixel_t left_q;
    sc3_pkg::pixel_t down_q;

    sc3_pixel_cell u_cell_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_valid_reg),
        .pixel_d  (older_q),
        .pixel_q  (up_q)
    );

    sc3_pixel_cell u_cell_mid0
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_valid_reg),
        .pixel_d  (newer_q),
        .pixel_q  (center_q)
    );

    sc3_pixel_cell u_cell_mid1
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_valid_reg),
        .pixel_d  (center_q),
        .pixel_q  (left_q)
    );

    sc3_pixel_cell u_cell_bot
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_valid_reg),
        .pixel_d  (s1_pixel_reg),
        .pixel_q  (down_q)
    );

    // The window still holds the previous columns while the right-hand
    // neighbour arrives from the newer line memory.
    sc3_pkg::result_t result;
    logic             push;

    always_comb
    begin
        result.pixel = sc3_pkg::cross_stencil(up_q, down_q, left_q, newer_q, center_q);
        result.last  = s1_last_reg;
    end

    assign push = s1_valid_reg & s1_emit_reg;

    sc3_pkg::result_t                  head;
    logic                              not_empty;
    logic [sc3_pkg::OUT_CNT_W-1:0]     out_count;
    logic [sc3_pkg::OUT_CNT_W:0]       occupancy;

    sc3_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (m_tvalid & m_tready),
        .head      (head),
        .not_empty (not_empty),
        .count     (out_count)
    );

    // A request is taken only while the queue has room for every result
    // already on its way, so nothing is ever dropped under back-pressure.
    assign occupancy = (sc3_pkg::OUT_CNT_W + 1)'(out_count)
                     + (sc3_pkg::OUT_CNT_W + 1)'(push);
    assign s_tready  = (occupancy < (sc3_pkg::OUT_CNT_W + 1)'(sc3_pkg::OUT_DEPTH));

    assign m_tvalid = not_empty;
    assign m_tdata  = head.pixel;
    assign m_tlast  = head.last;

endmodule

### src/sc3_checker.sv
// Port-level checker for the 3x3 cross stencil, with its bind to the top
// level. Depends on stencil_3x3_cross_convolution.
module sc3_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An empty output comes alive only after an accepted input request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a matching input request");

    // Input is held off only while results are waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind stencil_3x3_cross_convolution sc3_checker u_sc3_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/sv/stencil_3x3_cross_convolution_checker.sv
`timescale 1ns / 1ps
// Checker for the 3x3 cross stencil: follows the configuration port and both streams,
// predicts every filtered pixel and compares it with the result that leaves the block.
// Depends on sc3_pkg.
module stencil_3x3_cross_convolution_checker
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sc3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sc3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast,
    output int                              failures,
    output int                              outstanding,
    output int                              checked
);

    sc3_pkg::pixel_t                  row_two_up [MAX_WIDTH];
    sc3_pkg::pixel_t                  row_one_up [MAX_WIDTH];
    sc3_pkg::pixel_t                  up_q;
    sc3_pkg::pixel_t                  centre_q;
    sc3_pkg::pixel_t                  left_q;
    sc3_pkg::pixel_t                  down_q;
    logic [sc3_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [sc3_pkg::HEIGHT_REG_W-1:0] height_reg;
    int                               col;
    int                               row;
    sc3_pkg::result_t                 filtered_q [$];
    sc3_pkg::result_t                 oldest;

    function automatic int effective_size(input int v, input int hi);
        if (v < sc3_pkg::MIN_SIZE)
            return sc3_pkg::MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Moves the window on by one pixel and queues the result that this pixel completes.
    task automatic take_pixel(input sc3_pkg::pixel_t below_right);
        int               w;
        int               h;
        int               acc;
        sc3_pkg::pixel_t  top_px;
        sc3_pkg::pixel_t  mid_px;
        sc3_pkg::result_t res;
        w      = effective_size(int'(width_reg), MAX_WIDTH);
        h      = effective_size(int'(height_reg), MAX_HEIGHT);
        top_px = row_two_up[col];
        mid_px = row_one_up[col];
        if (row >= 2 && col >= 2 && row < h && col < w)
        begin
            acc = int'(up_q) + int'(down_q) + int'(left_q) + int'(mid_px)
                  - sc3_pkg::CENTER_GAIN * int'(centre_q);
            res.pixel = sc3_pkg::pixel_t'(acc);
            res.last  = (row == h - 1) && (col == w - 1);
            filtered_q.push_back(res);
        end
        up_q            = top_px;
        left_q          = centre_q;
        centre_q        = mid_px;
        down_q          = below_right;
        row_two_up[col] = mid_px;
        row_one_up[col] = below_right;
        if (col + 1 >= w)
        begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end
        else
        begin
            col = col + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                row_two_up[i] = '0;
                row_one_up[i] = '0;
            end
            up_q        = '0;
            centre_q    = '0;
            left_q      = '0;
            down_q      = '0;
            width_reg   = sc3_pkg::WIDTH_RESET;
            height_reg  = sc3_pkg::HEIGHT_RESET;
            col         = 0;
            row         = 0;
            filtered_q.delete();
            failures    = 0;
            checked     = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == sc3_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_data[sc3_pkg::WIDTH_REG_W-1:0];
                else if (cfg_index == sc3_pkg::REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[sc3_pkg::HEIGHT_REG_W-1:0];
            end
            // Results compared before the new pixel is taken in: a pixel's result is registered
            // in the block before it is offered, so it can never belong to the pixel accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("unexpected result: pixel_out %0d, last_pixel %0b", m_tdata, m_tlast);
                    failures++;
                end
                else
                begin
                    oldest = filtered_q.pop_front();
                    checked++;
                    if (m_tdata !== oldest.pixel)
                    begin
                        $error("pixel_out: expected %0d, got %0d", oldest.pixel, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== oldest.last)
                    begin
                        $error("last_pixel: expected %0b, got %0b", oldest.last, m_tlast);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_pixel(s_tdata);
            outstanding = filtered_q.size();
        end
    end

endmodule

### tb/sv/stencil_3x3_cross_convolution_tb.sv
`timescale 1ns / 1ps
// Testbench top for the 3x3 cross stencil: clock, reset, pixel stimulus, output back-pressure
// and the verdict. Depends on sc3_pkg, the block and stencil_3x3_cross_convolution_checker.
module stencil_3x3_cross_convolution_tb;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [sc3_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sc3_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;

    int   failures;
    int   outstanding;
    int   checked;

    // Percentages of cycles in which the pixel source and the result sink hold back.
    int   tx_idle_pct = 22;
    int   rx_idle_pct = 46;
    int   pixels_sent = 0;
    int   size_writes = 0;
    bit   stall_go    = 1'b0;
    logic long_stall  = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stencil_3x3_cross_convolution
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] pixel_in
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] pixel_out
        .m_tlast   (m_tlast)    // last_pixel
    );

    stencil_3x3_cross_convolution_checker
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // The result sink. It takes results at random according to rx_idle_pct, except while
    // the long stall is running, when it refuses everything so that the result queue
    // fills and the block has to refuse pixels in turn.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !long_stall && ($urandom_range(99) >= rx_idle_pct);
    end

    // The long stall counts its own cycles, so the pixel source carries on offering
    // requests throughout and is held up only by s_tready.
    initial
    begin
        wait (stall_go);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_stall <= 1'b0;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("[stencil_3x3_cross_convolution] ERROR");
        $finish;
    end

    // Random pixel, with black and white favoured so that the wrap-around of the sum is
    // pushed to both ends often.
    function automatic sc3_pkg::pixel_t rand_pixel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return sc3_pkg::pixel_t'($urandom_range(255));
        endcase
    endfunction

    function automatic int at_least_three(input int v);
        return (v < sc3_pkg::MIN_SIZE) ? sc3_pkg::MIN_SIZE : v;
    endfunction

    // Offers one pixel request, after a random gap, and returns at the edge where it is
    // accepted. tvalid stays high so that back-to-back requests need no gap.
    task automatic send_pixel(input sc3_pkg::pixel_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Stops offering pixels until every predicted result has left, then waits on
    // because border pixels may still be in the pipeline without a result to show.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes both size registers; only ever called once the block has settled.
    task automatic set_size(input int w, input int h);
        cfg_wr_en <= 1'b1;
        cfg_index <= sc3_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= sc3_pkg::CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= sc3_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= sc3_pkg::CFG_DATA_W'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        size_writes++;
    endtask

    // Mostly whole images of small random size, so that every row and column position and
    // the end-of-image flag come up often. Now and then an image is cut short and the next
    // size lands in the middle of it, and now and then a size below three is written.
    task automatic random_images(input int budget);
        int w;
        int h;
        int count;
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            settle();
            w = ($urandom_range(9) == 0) ? $urandom_range(11, 48) : $urandom_range(3, 10);
            h = $urandom_range(3, 8);
            if ($urandom_range(7) == 0)
                w = $urandom_range(0, 2);
            if ($urandom_range(7) == 0)
                h = $urandom_range(0, 2);
            set_size(w, h);
            count = at_least_three(w) * at_least_three(h);
            if ($urandom_range(4) == 0)
                count = $urandom_range(1, count - 1);
            else
                count = count * $urandom_range(1, 2);
            repeat (count) send_pixel(rand_pixel());
            sent += count;
        end
    endtask

    initial
    begin
        int i;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= sc3_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A 48-pixel-wide image first. No later image is wider, so after it every line
        // memory entry that a later size change can reach holds a known pixel.
        set_size(48, 3);
        repeat (48 * 3) send_pixel(rand_pixel());
        settle();

        // Directed: a 4x4 checkerboard puts white centres among black neighbours and the
        // reverse, the two ends of the wrapped sum.
        set_size(4, 4);
        for (i = 0; i < 16; i++)
            send_pixel((((i / 4) + (i % 4)) % 2 == 1) ? 8'hFF : 8'h00);
        settle();

        // Directed: sizes below the minimum give a 3x3 image with a single interior pixel,
        // which is also the last one. A black centre among white neighbours.
        set_size(1, 2);
        for (i = 0; i < 9; i++)
            send_pixel((i == 4) ? 8'h00 : 8'hFF);
        settle();

        // All-ones sizes are clamped to the widest row and the tallest image. Only the
        // start of the first row is sent, and the next size lands in the middle of it.
        set_size(12'hFFF, 13'h1FFF);
        repeat (40) send_pixel(rand_pixel());

        random_images(520);

        tx_idle_pct = 46;
        rx_idle_pct = 22;
        random_images(520);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_images(520);

        // A narrow, tall image: a zero width is raised to three. The long output stall
        // falls inside it.
        settle();
        set_size(0, 30);
        stall_go = 1'b1;
        repeat (sc3_pkg::MIN_SIZE * 30) send_pixel(rand_pixel());

        settle();
        repeat (16) @(posedge clk);

        $display("Run covered %0d pixels over %0d size settings, %0d filtered pixels checked.",
                 pixels_sent, size_writes, checked);
        $display("It took in clamped sizes, sizes changed within an image and a long stall.");
        if (failures == 0 && outstanding == 0)
            $display("[stencil_3x3_cross_convolution] OK");
        else
            $display("[stencil_3x3_cross_convolution] ERROR");
        $finish;
    end

endmodule
